@@ sv/dmd_pkg.sv @@
// Shared types, constants and a compare-select helper for the decimating depth median filter.
`timescale 1ns / 1ps

package dmd_pkg;

    // Field widths.
    localparam int DEPTH_W     = 16;
    localparam int LW_W        = 10;
    localparam int OUT_COL_W   = 9;
    localparam int ROW_W       = 12;
    localparam int TDATA_OUT_W = 32;

    // Line width limits and reset value.
    localparam int             MAX_LINE_WIDTH_DEF = 640;
    localparam int             MIN_LINE_WIDTH     = 4;
    localparam logic [LW_W-1:0] LINE_WIDTH_RST    = 10'd640;

    typedef logic [DEPTH_W-1:0] t_pix;
    typedef logic [ROW_W-1:0]   t_row;

    // One window column, sorted from smallest to largest.
    typedef struct packed {
        t_pix lo;
        t_pix mid;
        t_pix hi;
    } t_col3;

    // What a request carries through the pipeline besides pixel data.
    typedef struct packed {
        logic                 emit;
        logic                 use_raw;
        logic [OUT_COL_W-1:0] out_col;
        logic                 last;
    } t_item_info;

    // Enables for the median datapath.
    typedef struct packed {
        logic shift;
        logic adv;
    } t_med_ctrl;

    // Sorts three values with three parallel compares. The low and high picks
    // always come from distinct positions, so the middle is what remains.
    function automatic t_col3 sort3(input t_pix a, input t_pix b, input t_pix c);
        logic  ab;
        logic  bc;
        logic  ac;
        t_col3 s;
        ab = (a > b);
        bc = (b > c);
        ac = (a > c);
        if (!ab && !ac) begin
            s.lo = a;
        end else if (!bc) begin
            s.lo = b;
        end else begin
            s.lo = c;
        end
        if (!ac && !bc) begin
            s.hi = c;
        end else if (ab) begin
            s.hi = a;
        end else begin
            s.hi = b;
        end
        s.mid = a ^ b ^ c ^ s.lo ^ s.hi;
        return s;
    endfunction

endpackage

@@ sv/dmd_line_buf.sv @@
// Two line buffers holding the previous two input rows, one entry per column.
`timescale 1ns / 1ps

module dmd_line_buf #(
    parameter int MAX_LINE_WIDTH = dmd_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [$clog2(MAX_LINE_WIDTH)-1:0] i_addr,
    input  dmd_pkg::t_pix                     i_pix,
    output dmd_pkg::t_pix                     o_older,
    output dmd_pkg::t_pix                     o_newer
);

    localparam int AW = $clog2(MAX_LINE_WIDTH);

    dmd_pkg::t_pix r_older_mem [MAX_LINE_WIDTH];
    dmd_pkg::t_pix r_newer_mem [MAX_LINE_WIDTH];

    dmd_pkg::t_pix r_rd_older;
    dmd_pkg::t_pix r_rd_newer;
    logic [AW-1:0] r_addr;
    logic          r_pend;
    logic          r_fwd;
    dmd_pkg::t_pix r_fwd_data;

    // The newer row is written with the incoming pixel at the read edge
    // (read-first), and the older row takes the old newer entry in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_newer          <= r_newer_mem[i_addr];
            r_newer_mem[i_addr] <= i_pix;
            r_rd_older          <= r_older_mem[i_addr];
            r_addr              <= i_addr;
            r_fwd_data          <= r_rd_newer;
        end
        if (r_pend) begin
            r_older_mem[r_addr] <= r_rd_newer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_fwd  <= 1'b0;
        end else begin
            r_pend <= i_rd_en;
            if (i_rd_en) begin
                // Back-to-back requests at one column: the older write is still pending.
                r_fwd <= r_pend && (r_addr == i_addr);
            end
        end
    end

    assign o_older = r_fwd ? r_fwd_data : r_rd_older;
    assign o_newer = r_rd_newer;

endmodule

@@ sv/dmd_median.sv @@
// 3x3 window of sorted columns and the two-stage median-of-nine network.
`timescale 1ns / 1ps

module dmd_median (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dmd_pkg::t_med_ctrl i_ctrl,
    input  dmd_pkg::t_pix      i_older,
    input  dmd_pkg::t_pix      i_newer,
    input  dmd_pkg::t_pix      i_pix,
    output dmd_pkg::t_pix      o_median
);

    dmd_pkg::t_col3 r_win [3];
    dmd_pkg::t_pix  r_lo_max;
    dmd_pkg::t_pix  r_mid_med;
    dmd_pkg::t_pix  r_hi_min;

    dmd_pkg::t_col3 n_col;
    dmd_pkg::t_col3 n_los;
    dmd_pkg::t_col3 n_mids;
    dmd_pkg::t_col3 n_his;
    dmd_pkg::t_col3 n_final;

    always_comb begin
        n_col   = dmd_pkg::sort3(i_older, i_newer, i_pix);
        n_los   = dmd_pkg::sort3(r_win[0].lo, r_win[1].lo, r_win[2].lo);
        n_mids  = dmd_pkg::sort3(r_win[0].mid, r_win[1].mid, r_win[2].mid);
        n_his   = dmd_pkg::sort3(r_win[0].hi, r_win[1].hi, r_win[2].hi);
        n_final = dmd_pkg::sort3(r_lo_max, r_mid_med, r_hi_min);
    end

    // Window columns shift in as each request passes; reset clears them to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (i_ctrl.shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= n_col;
        end
    end

    // The median of nine is the median of the largest low, the middle mid
    // and the smallest high across the sorted columns.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_lo_max  <= n_los.hi;
            r_mid_med <= n_mids.mid;
            r_hi_min  <= n_his.lo;
        end
    end

    assign o_median = n_final.mid;

endmodule

@@ sv/depth_median3x3_decimate.sv @@
// A result passes line buffer reads, window and partial medians, then the output register.
// Throughput: one pixel per cycle; each stage holds while the next one is full.
// Pixels at odd row and odd column finish a window; three of four pixels give no result.
// Reset (synchronous, active low) clears counters, window, pipeline valids; width goes to 640.
// Line buffers get no clearing and hold whatever was written last.
`timescale 1ns / 1ps

module depth_median3x3_decimate #(
    parameter int MAX_LINE_WIDTH = dmd_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: line width in input pixels.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dmd_pkg::LW_W-1:0]        i_cfg_data,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dmd_pkg::DEPTH_W-1:0]     s_axis_tdata,  // [15:0] depth_in
    input  logic                            s_axis_tuser,  // [0] frame_start
    // Output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dmd_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // [15:0] filtered_depth,
                                                           // [24:16] out_col, rest zero
    output logic                            m_axis_tlast   // row_last
);

    localparam int AW    = $clog2(MAX_LINE_WIDTH);
    localparam int CNT_W = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CMP_W = CNT_W + dmd_pkg::LW_W;

    // Configuration register. Writes are taken in any cycle; the user writes
    // only while the pipeline is empty.
    logic [dmd_pkg::LW_W-1:0] r_line_width;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= dmd_pkg::LINE_WIDTH_RST;
        end else if (i_cfg_valid) begin
            r_line_width <= i_cfg_data;
        end
    end

    // Pipeline handshake. Stage 1 holds the line buffer reads, stage 2 the
    // window, stage 3 the partial medians, then the output register. A stage
    // is free when empty or moving on; a stage 3 request with no result just
    // drops out, so only emitting requests wait on the output register.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_out_valid;
    logic out_free;
    logic move1;
    logic move2;
    logic move3;
    logic free1;
    logic free2;
    logic free3;
    logic accept;

    dmd_pkg::t_item_info r_s1;
    dmd_pkg::t_item_info r_s2;
    dmd_pkg::t_item_info r_s3;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign move3         = r_v3 && (!r_s3.emit || out_free);
    assign free3         = !r_v3 || move3;
    assign move2         = r_v2 && free3;
    assign free2         = !r_v2 || free3;
    assign move1         = r_v1 && free2;
    assign free1         = !r_v1 || free2;
    assign s_axis_tready = free1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Position counters. The effective width is the register clamped to the
    // supported range and rounded down to even. A frame start clears the
    // counters before the pixel is placed; a row whose column count already
    // reached the width (width lowered) is closed first.
    logic [CNT_W-1:0]    r_col;
    dmd_pkg::t_row       r_row;
    logic [CMP_W-1:0]    lw_ext;
    logic [CMP_W-1:0]    w_clamp;
    logic [CMP_W-1:0]    w_eff;
    logic [CMP_W-1:0]    col_start;
    dmd_pkg::t_row       row_start;
    logic [CMP_W-1:0]    c_cur;
    dmd_pkg::t_row       r_cur;
    logic [CMP_W-1:0]    c_next;
    logic [CNT_W-1:0]    n_col;
    dmd_pkg::t_row       n_row;
    dmd_pkg::t_item_info n_info;

    always_comb begin
        lw_ext = CMP_W'(r_line_width);
        if (lw_ext < CMP_W'(dmd_pkg::MIN_LINE_WIDTH)) begin
            w_clamp = CMP_W'(dmd_pkg::MIN_LINE_WIDTH);
        end else if (lw_ext > CMP_W'(MAX_LINE_WIDTH)) begin
            w_clamp = CMP_W'(MAX_LINE_WIDTH);
        end else begin
            w_clamp = lw_ext;
        end
        w_eff = {w_clamp[CMP_W-1:1], 1'b0};

        col_start = s_axis_tuser ? '0 : CMP_W'(r_col);
        row_start = s_axis_tuser ? '0 : r_row;
        if (col_start >= w_eff) begin
            c_cur = '0;
            r_cur = row_start + dmd_pkg::t_row'(1);
        end else begin
            c_cur = col_start;
            r_cur = row_start;
        end

        c_next = c_cur + CMP_W'(1);
        if (c_next >= w_eff) begin
            n_col = '0;
            n_row = r_cur + dmd_pkg::t_row'(1);
        end else begin
            n_col = c_next[CNT_W-1:0];
            n_row = r_cur;
        end

        // The window centered one row up and one column left is complete.
        n_info.emit    = r_cur[0] && c_cur[0];
        n_info.use_raw = (r_cur == dmd_pkg::t_row'(1)) || (c_cur == CMP_W'(1));
        n_info.out_col = c_cur[dmd_pkg::OUT_COL_W:1];
        n_info.last    = (c_cur == (w_eff - CMP_W'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line buffers: read at the current column on accept, registered.
    dmd_pkg::t_pix older_val;
    dmd_pkg::t_pix newer_val;

    dmd_line_buf #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (accept),
        .i_addr  (c_cur[AW-1:0]),
        .i_pix   (s_axis_tdata),
        .o_older (older_val),
        .o_newer (newer_val)
    );

    // Stage payloads. The raw center of a window is the middle row of the
    // column before the newest, i.e. the newer-row value of the last request.
    dmd_pkg::t_pix r_pix1;
    dmd_pkg::t_pix r_prev_mid;
    dmd_pkg::t_pix r_raw2;
    dmd_pkg::t_pix r_raw3;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix1 <= s_axis_tdata;
            r_s1   <= n_info;
        end
        if (move1) begin
            r_raw2 <= r_prev_mid;
            r_s2   <= r_s1;
        end
        if (move2) begin
            r_raw3 <= r_raw2;
            r_s3   <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mid <= '0;
        end else if (move1) begin
            r_prev_mid <= newer_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (move1) begin
                r_v1 <= 1'b0;
            end
            if (move1) begin
                r_v2 <= 1'b1;
            end else if (move2) begin
                r_v2 <= 1'b0;
            end
            if (move2) begin
                r_v3 <= 1'b1;
            end else if (move3) begin
                r_v3 <= 1'b0;
            end
        end
    end

    // Median datapath: window shifts as a request enters stage 2, partial
    // medians register as it enters stage 3.
    dmd_pkg::t_med_ctrl med_ctrl;
    dmd_pkg::t_pix      median_val;

    assign med_ctrl.shift = move1;
    assign med_ctrl.adv   = move2;

    dmd_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (med_ctrl),
        .i_older  (older_val),
        .i_newer  (newer_val),
        .i_pix    (r_pix1),
        .o_median (median_val)
    );

    // Output register.
    dmd_pkg::t_pix                  r_out_depth;
    logic [dmd_pkg::OUT_COL_W-1:0]  r_out_col;
    logic                           r_out_last;

    always_ff @(posedge i_clk) begin
        if (move3 && r_s3.emit) begin
            r_out_depth <= r_s3.use_raw ? r_raw3 : median_val;
            r_out_col   <= r_s3.out_col;
            r_out_last  <= r_s3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move3 && r_s3.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(dmd_pkg::TDATA_OUT_W - dmd_pkg::OUT_COL_W - dmd_pkg::DEPTH_W){1'b0}},
                            r_out_col, r_out_depth};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // An emitting request leaving stage 3 always lands in the output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move3 && r_s3.emit) |=> m_axis_tvalid)
        else $error("emitting request did not reach the output register");

    // An accepted request always occupies stage 1 on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted request lost before stage 1");

    // A request with no result never makes the output valid.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !(move3 && r_s3.emit)) |=> !m_axis_tvalid)
        else $error("output valid raised without an emitting request");

    // Input back-pressure only when stage 1 is full and blocked downstream.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3 && !move3))
        else $error("input stalled while the pipeline could advance");
`endif

endmodule
